// File: hdl/aesri_pkg.sv
package aesri_pkg;

    typedef enum logic [2:0] {
        OP_ENC      = 3'd0,
        OP_ENC_LAST = 3'd1,
        OP_DEC      = 3'd2,
        OP_DEC_LAST = 3'd3,
        OP_IMC      = 3'd4,
        OP_KEYGEN   = 3'd5
    } t_op;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] state_lo;
        logic [63:0] state_hi;
        logic [63:0] key_lo;
        logic [63:0] key_hi;
        logic [7:0]  round_const;
    } t_in_word;

    typedef struct packed {
        logic [63:0] result_lo;
        logic [63:0] result_hi;
    } t_out_word;

    // per-lane control decoded once from the selector
    typedef struct packed {
        logic use_key_src;   // mix stage reads the source instead of sub output
        logic inverse;
        logic do_sub;
        logic do_mix;
        logic add_key;
        logic keygen;
        logic zero;
    } t_lane_ctl;

    localparam int NLanes = 4;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] t;
        r = 8'h00;
        t = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r = r ^ t;
            t = xtime(t);
        end
        gf_mul = r;
    endfunction

    function automatic logic [7:0] gf_inv(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] b;
        r = 8'h01;
        b = x;
        for (int i = 0; i < 8; i++) begin
            if (i != 0) r = gf_mul(r, b);
            b = gf_mul(b, b);
        end
        gf_inv = r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] b, input int n);
        rotl8 = (b << n) | (b >> (8 - n));
    endfunction

    function automatic logic [7:0] sbox_calc(input logic [7:0] x);
        logic [7:0] b;
        b = gf_inv(x);
        sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] inv_sbox_calc(input logic [7:0] x);
        inv_sbox_calc = gf_inv(rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ 8'h05);
    endfunction

    typedef logic [7:0] t_tab [256];

    function automatic t_tab make_sbox(input logic inverse);
        t_tab t;
        for (int i = 0; i < 256; i++) begin
            t[i] = inverse ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
        end
        make_sbox = t;
    endfunction

    localparam t_tab SboxFwd = make_sbox(1'b0);
    localparam t_tab SboxInv = make_sbox(1'b1);

endpackage

// File: hdl/aesri_lane.sv
// one state column: substitution, column mix and key add
module aesri_lane (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  aesri_pkg::t_lane_ctl  i_ctl,
    input  logic [31:0]           i_col,     // shifted state column, or source dword
    input  logic [31:0]           i_key,
    input  logic [7:0]            i_rcon,
    output logic [31:0]           o_col
);
    logic [31:0] sub_col;
    logic [31:0] r_sub;
    logic [31:0] r_key;
    logic [7:0]  r_rcon;
    aesri_pkg::t_lane_ctl r_ctl;
    logic [31:0] mix_in;
    logic [31:0] mixed;
    logic [31:0] kg;
    logic [31:0] n_col;
    logic [31:0] r_col;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            sub_col[8*r +: 8] = i_ctl.inverse ? aesri_pkg::SboxInv[i_col[8*r +: 8]]
                                              : aesri_pkg::SboxFwd[i_col[8*r +: 8]];
        end
    end

    // stage one: s-box lookup
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sub  <= i_ctl.use_key_src ? i_col : sub_col;
            r_key  <= i_key;
            r_rcon <= i_rcon;
            r_ctl  <= i_ctl;
        end
    end

    assign mix_in = r_sub;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            if (r_ctl.inverse) begin
                mixed[8*r +: 8] = aesri_pkg::gf_mul(8'h0e, mix_in[8*r +: 8])
                    ^ aesri_pkg::gf_mul(8'h0b, mix_in[8*((r+1)%4) +: 8])
                    ^ aesri_pkg::gf_mul(8'h0d, mix_in[8*((r+2)%4) +: 8])
                    ^ aesri_pkg::gf_mul(8'h09, mix_in[8*((r+3)%4) +: 8]);
            end else begin
                mixed[8*r +: 8] = aesri_pkg::gf_mul(8'h02, mix_in[8*r +: 8])
                    ^ aesri_pkg::gf_mul(8'h03, mix_in[8*((r+1)%4) +: 8])
                    ^ mix_in[8*((r+2)%4) +: 8]
                    ^ mix_in[8*((r+3)%4) +: 8];
            end
        end
        // keygen lanes receive the substituted source word in r_sub
        kg = {r_sub[7:0], r_sub[31:24], r_sub[23:16], r_sub[15:8] ^ r_rcon};
        if (r_ctl.zero) begin
            n_col = '0;
        end else if (r_ctl.keygen) begin
            n_col = r_key[0] ? kg : r_sub;
        end else begin
            n_col = (r_ctl.do_mix ? mixed : r_sub) ^ (r_ctl.add_key ? r_key : 32'h0);
        end
    end

    // stage two: mix and key add
    always_ff @(posedge i_clk) begin
        if (i_en) r_col <= n_col;
    end

    assign o_col = r_col;
endmodule

// File: hdl/aes_round_instruction_unit_core.sv
// aes round instruction unit
// input channel i_valid/o_ready carries one word: selector, 128-bit state,
// 128-bit round key or source, round constant. output channel o_valid/i_ready
// returns one 128-bit result word per input word.
// selectors: encrypt round, last encrypt round, decrypt round, last decrypt
// round, invmixcolumns of the source, keygen assist; unused codes give zero.
// four column lanes run side by side, the byte routing (shift rows, keygen
// word pick) sits ahead of them and the merge stage packs the columns.
// the pipeline registers are: s-box stage, mix/key stage, output register.
// throughput is one word per cycle; the three stages form a pipeline that
// advances whenever the output register is empty or being taken.
// when i_ready is low and the output register holds a word the whole pipeline
// holds and o_ready drops; no stage can move.
// reset (i_rst_n low, synchronous) clears the stage valid bits; data
// registers are not reset.
module aes_round_instruction_unit_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  aesri_pkg::t_in_word   i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output aesri_pkg::t_out_word  o_data
);
    logic [2:0] r_vld;
    logic       adv;
    logic [127:0] st, key, shifted, lane_in, lane_key, lane_out;
    logic [3:0] kg_sel;
    aesri_pkg::t_lane_ctl ctl;

    assign adv     = !r_vld[2] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    assign st  = {i_data.state_hi, i_data.state_lo};
    assign key = {i_data.key_hi, i_data.key_lo};

    always_comb begin
        ctl = '0;
        unique case (i_data.op)
            aesri_pkg::OP_ENC:      begin ctl.do_mix = 1'b1; ctl.add_key = 1'b1; end
            aesri_pkg::OP_ENC_LAST: ctl.add_key = 1'b1;
            aesri_pkg::OP_DEC:      begin
                ctl.inverse = 1'b1; ctl.do_mix = 1'b1; ctl.add_key = 1'b1;
            end
            aesri_pkg::OP_DEC_LAST: begin ctl.inverse = 1'b1; ctl.add_key = 1'b1; end
            aesri_pkg::OP_IMC:      begin
                ctl.inverse = 1'b1; ctl.do_mix = 1'b1; ctl.use_key_src = 1'b1;
            end
            aesri_pkg::OP_KEYGEN:   ctl.keygen = 1'b1;
            default:                ctl.zero = 1'b1;
        endcase
        ctl.do_sub = !ctl.use_key_src;
    end

    // byte routing into the lanes
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (ctl.inverse)
                    shifted[8*(4*c+r) +: 8] = st[8*((4*(c-r+4)+r) & 15) +: 8];
                else
                    shifted[8*(4*c+r) +: 8] = st[8*((4*(c+r)+r) & 15) +: 8];
            end
        end
        if (ctl.keygen) begin
            // lanes 0,1 take source dword 1, lanes 2,3 take dword 3
            lane_in  = {key[127:96], key[127:96], key[63:32], key[63:32]};
            kg_sel   = 4'b1010;
        end else if (ctl.use_key_src) begin
            lane_in  = key;
            kg_sel   = 4'b0000;
        end else begin
            lane_in  = shifted;
            kg_sel   = 4'b0000;
        end
        for (int l = 0; l < 4; l++) begin
            lane_key[32*l +: 32] = ctl.keygen ? {31'h0, kg_sel[l]} : key[32*l +: 32];
        end
    end

    for (genvar l = 0; l < aesri_pkg::NLanes; l++) begin : g_lane
        aesri_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_ctl  (ctl),
            .i_col  (lane_in[32*l +: 32]),
            .i_key  (lane_key[32*l +: 32]),
            .i_rcon (i_data.round_const),
            .o_col  (lane_out[32*l +: 32])
        );
    end

    // merge stage
    aesri_pkg::t_out_word r_out;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.result_lo <= lane_out[63:0];
            r_out.result_hi <= lane_out[127:64];
        end
    end
    assign o_data = r_out;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output word changed under stall");
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("ready mismatch");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_ready ##1 i_ready ##1 i_ready |=> o_valid)
        else $error("word lost in pipeline");
endmodule

// File: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumRandom = 1000;
    localparam int Latency   = 3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    aesri_pkg::t_in_word  i_data;
    logic                 o_valid;
    logic                 i_ready;
    aesri_pkg::t_out_word o_data;

    aes_round_instruction_unit_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    aesri_pkg::t_out_word result_queue[$];
    int        n_errors;
    int        n_results;
    int        op_seen[8];
    bit        send_idle_ok;
    bit        recv_idle_ok;
    bit        sending;
    logic [7:0] fwd_sbox[256];
    logic [7:0] inv_sbox[256];

    // gf(2^8) helpers for the predictor
    function automatic logic [7:0] field_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [7:0] field_inverse(logic [7:0] x);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 1; i < 256; i++) begin
            if (field_mul(x, 8'(i)) == 8'h01) r = 8'(i);
        end
        return r;
    endfunction

    function automatic logic [7:0] rol8(logic [7:0] b, int n);
        return (b << n) | (b >> (8 - n));
    endfunction

    task automatic build_sboxes();
        logic [7:0] v;
        for (int i = 0; i < 256; i++) begin
            v = field_inverse(8'(i));
            fwd_sbox[i] = v ^ rol8(v, 1) ^ rol8(v, 2) ^ rol8(v, 3) ^ rol8(v, 4) ^ 8'h63;
        end
        for (int i = 0; i < 256; i++) inv_sbox[fwd_sbox[i]] = 8'(i);
    endtask

    function automatic logic [127:0] mix_columns(logic [127:0] s, bit inverse);
        logic [7:0]   k[4];
        logic [7:0]   acc;
        logic [127:0] r;
        if (inverse) k = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else k = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++) begin
            for (int row = 0; row < 4; row++) begin
                acc = 8'h00;
                for (int j = 0; j < 4; j++)
                    acc ^= field_mul(k[j], s[8*(4*c + ((row + j) & 3)) +: 8]);
                r[8*(4*c + row) +: 8] = acc;
            end
        end
        return r;
    endfunction

    function automatic aesri_pkg::t_out_word aes_result(aesri_pkg::t_in_word w);
        logic [127:0] st;
        logic [127:0] key;
        logic [127:0] t;
        logic [127:0] res;
        logic [7:0]   sw[4];
        aesri_pkg::t_out_word o;
        bit           inv;
        st  = {w.state_hi, w.state_lo};
        key = {w.key_hi, w.key_lo};
        res = '0;
        inv = (w.op == aesri_pkg::OP_DEC) || (w.op == aesri_pkg::OP_DEC_LAST);
        case (w.op)
            aesri_pkg::OP_ENC, aesri_pkg::OP_ENC_LAST,
            aesri_pkg::OP_DEC, aesri_pkg::OP_DEC_LAST: begin
                for (int c = 0; c < 4; c++) begin
                    for (int row = 0; row < 4; row++) begin
                        if (inv)
                            t[8*(4*c+row) +: 8] =
                                inv_sbox[st[8*((4*(c - row + 4) + row) & 15) +: 8]];
                        else
                            t[8*(4*c+row) +: 8] =
                                fwd_sbox[st[8*((4*(c + row) + row) & 15) +: 8]];
                    end
                end
                if (w.op == aesri_pkg::OP_ENC || w.op == aesri_pkg::OP_DEC)
                    t = mix_columns(t, inv);
                res = t ^ key;
            end
            aesri_pkg::OP_IMC: res = mix_columns(key, 1'b1);
            aesri_pkg::OP_KEYGEN: begin
                for (int h = 0; h < 2; h++) begin
                    for (int i = 0; i < 4; i++) sw[i] = fwd_sbox[key[8*(4 + 8*h + i) +: 8]];
                    for (int i = 0; i < 4; i++) begin
                        res[8*(8*h + i) +: 8]     = sw[i];
                        res[8*(8*h + 4 + i) +: 8] = sw[(i + 1) & 3];
                    end
                    res[8*(8*h + 4) +: 8] ^= w.round_const;
                end
            end
            default: res = '0;
        endcase
        o.result_lo = res[63:0];
        o.result_hi = res[127:64];
        return o;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        n_errors++;
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // send one word, holding it until accepted
    task automatic send_word(aesri_pkg::t_in_word w);
        while (send_idle_ok && $urandom_range(0, 99) < 11) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        result_queue.push_back(aes_result(w));
        op_seen[w.op]++;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // receiver side: random stalls, compare each word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (result_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h", o_data));
                end else begin
                    if (o_data.result_lo !== result_queue[0].result_lo)
                        report_mismatch($sformatf("result_lo got %h expected %h",
                                        o_data.result_lo, result_queue[0].result_lo));
                    if (o_data.result_hi !== result_queue[0].result_hi)
                        report_mismatch($sformatf("result_hi got %h expected %h",
                                        o_data.result_hi, result_queue[0].result_hi));
                    void'(result_queue.pop_front());
                    n_results++;
                end
            end
            i_ready <= !(recv_idle_ok && $urandom_range(0, 99) < 11);
        end
    end

    typedef struct {
        aesri_pkg::t_in_word  w;
        bit                   has_fixed;
        aesri_pkg::t_out_word fixed;
    } t_row;

    initial begin
        t_row     rows[$];
        t_row     r;
        aesri_pkg::t_in_word w;
        int       waited;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_ready      = 1'b0;
        i_data       = '0;
        n_errors     = 0;
        n_results    = 0;
        send_idle_ok = 1'b1;
        recv_idle_ok = 1'b1;
        build_sboxes();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: fixed answers only where obvious
        r = '{w: '{aesri_pkg::OP_IMC, '0, '0, '0, '0, 8'h00}, has_fixed: 1, fixed: '0};
        rows.push_back(r);
        r = '{w: '{aesri_pkg::OP_KEYGEN, '1, '1, '0, '0, 8'h00}, has_fixed: 1,
              fixed: '{64'h6363636363636363, 64'h6363636363636363}};
        rows.push_back(r);
        r = '{w: '{aesri_pkg::OP_DEC_LAST, '0, '0, '0, '0, 8'h00}, has_fixed: 1,
              fixed: '{64'h5252525252525252, 64'h5252525252525252}};
        rows.push_back(r);
        r = '{w: '{aesri_pkg::OP_ENC_LAST, '0, '0, '1, '1, 8'hff}, has_fixed: 1,
              fixed: '{64'h9c9c9c9c9c9c9c9c, 64'h9c9c9c9c9c9c9c9c}};
        rows.push_back(r);
        r = '{w: '{3'd6, '1, '1, '1, '1, 8'hff}, has_fixed: 1, fixed: '0};
        rows.push_back(r);
        r = '{w: '{3'd7, '1, '1, '1, '1, 8'hff}, has_fixed: 1, fixed: '0};
        rows.push_back(r);
        for (int op = 0; op < 6; op++) begin
            r = '{w: '{3'(op), '1, '1, '1, '1, 8'hff}, has_fixed: 0, fixed: '0};
            rows.push_back(r);
            r = '{w: '{3'(op), 64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                       64'h8877665544332211, 64'h00ffeeddccbbaa99, 8'h80},
                  has_fixed: 0, fixed: '0};
            rows.push_back(r);
        end
        r = '{w: '{aesri_pkg::OP_KEYGEN, '0, '0, 64'h0123456789abcdef,
                   64'hfedcba9876543210, 8'h01},
              has_fixed: 0, fixed: '0};
        rows.push_back(r);

        foreach (rows[i]) begin
            send_word(rows[i].w);
            if (rows[i].has_fixed && aes_result(rows[i].w) != rows[i].fixed)
                report_mismatch($sformatf("predictor disagrees with table row %0d", i));
        end

        for (int n = 0; n < NumRandom; n++) begin
            // no idling on either side for a stretch
            send_idle_ok = !(n >= 300 && n < 450);
            recv_idle_ok = send_idle_ok;
            if (n == 600) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (result_queue.size() != 0) @(posedge i_clk);
            end
            w.op          = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                         : 3'($urandom_range(0, 5));
            w.state_lo    = rand64();
            w.state_hi    = rand64();
            w.key_lo      = rand64();
            w.key_hi      = rand64();
            w.round_const = 8'($urandom);
            send_word(w);
        end
        i_valid <= 1'b0;
        recv_idle_ok = 1'b1;

        waited = 0;
        while (result_queue.size() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (Latency + 4) @(posedge i_clk);
        if (result_queue.size() != 0)
            report_mismatch($sformatf("%0d words never came", result_queue.size()));
        $display("covered %0d words: enc %0d, enc last %0d, dec %0d, dec last %0d",
                 n_results, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
        $display("imc %0d, keygen %0d, unused selectors %0d, errors %0d",
                 op_seen[4], op_seen[5], op_seen[6] + op_seen[7], n_errors);
        if (n_errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        #200us;
        $display("timeout");
        $display("status: fail");
        $finish;
    end
endmodule
